### rtl/rrsm_pkg.sv
`timescale 1ns / 1ps

package rrsm_pkg;

  // slots held by one cell of the row
  localparam int CELL_SLOTS = 8;
  localparam int CELL_SEL_W = 3;

  // widths that cover the largest ring the block can be built for (64 slots)
  localparam int IDX_W = 6;
  localparam int CNT_W = 7;

  localparam int DEF_MAX_SLOTS = 32;

  localparam int ADDR_W = 48;
  localparam int LEN_W = 17;
  localparam int CFG_IDX_W = 3;

  typedef enum logic [1:0] {
    OP_ALLOC     = 2'd0,
    OP_RECV_DONE = 2'd1,
    OP_FETCH     = 2'd2,
    OP_ACK       = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    STAT_OK        = 3'd0,
    STAT_INV_EP    = 3'd1,
    STAT_NO_SPACE  = 3'd2,
    STAT_INV_MSG   = 3'd3,
    STAT_EMPTY     = 3'd4,
    STAT_TOO_BIG   = 3'd5
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BUFFER_BASE     = 3'd0,
    REG_SLOT_COUNT_LOG2 = 3'd1,
    REG_SLOT_SIZE_LOG2  = 3'd2,
    REG_ENDPOINT_OWNER  = 3'd3,
    REG_RUNNING_OWNER   = 3'd4
  } reg_idx_t;

  // search request and probe, broadcast to every cell
  typedef struct packed {
    logic             want_unread;
    logic [CNT_W-1:0] start;
    logic [CNT_W-1:0] total;
    logic [IDX_W-1:0] probe;
  } search_t;

  // bitmap update, applied by the cell that owns the slot
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] idx;
    logic             set_occ;
    logic             clr_occ;
    logic             set_unr;
    logic             clr_unr;
  } cmd_t;

  // partial results handed from cell to cell
  typedef struct packed {
    logic             found_hi;
    logic [IDX_W-1:0] idx_hi;
    logic             found_lo;
    logic [IDX_W-1:0] idx_lo;
    logic             probe_occ;
    logic             probe_unr;
    logic [CNT_W-1:0] count;
  } chain_t;

endpackage

### rtl/rrsm_cell.sv
`timescale 1ns / 1ps

module rrsm_cell #(
  parameter int CELL_ID = 0
) (
  input  logic              clk,
  input  logic              rst,
  input  rrsm_pkg::search_t srch,
  input  rrsm_pkg::cmd_t    cmd,
  input  rrsm_pkg::chain_t  chain_in,
  output rrsm_pkg::chain_t  chain_out
);

  localparam int G  = rrsm_pkg::CELL_SLOTS;
  localparam int LW = rrsm_pkg::CELL_SEL_W;
  localparam int IW = rrsm_pkg::IDX_W;
  localparam int CW = rrsm_pkg::CNT_W;

  logic [G-1:0]    occ;
  logic [G-1:0]    unr;
  logic [G-1:0]    hi;
  logic [G-1:0]    lo;
  logic            loc_found_hi;
  logic            loc_found_lo;
  logic [LW-1:0]   loc_idx_hi;
  logic [LW-1:0]   loc_idx_lo;
  logic [CW-1:0]   loc_count;
  logic            probe_hit;
  logic            cmd_hit;
  rrsm_pkg::chain_t chain_next;

  // candidates: in the ring, bit as wanted; split at the search start
  always_comb begin
    logic [CW-1:0] j;
    logic          cand;
    hi = '0;
    lo = '0;
    for (int l = 0; l < G; l++) begin
      j    = CW'(CELL_ID * G + l);
      cand = (srch.want_unread ? unr[l] : !occ[l]) && (j < srch.total);
      hi[l] = cand && (j >= srch.start);
      lo[l] = cand && (j < srch.start);
    end
  end

  // lowest candidate of each half
  always_comb begin
    loc_idx_hi = '0;
    loc_idx_lo = '0;
    for (int l = G - 1; l >= 0; l--) begin
      if (hi[l]) begin
        loc_idx_hi = LW'(l);
      end
      if (lo[l]) begin
        loc_idx_lo = LW'(l);
      end
    end
    loc_found_hi = |hi;
    loc_found_lo = |lo;
  end

  always_comb begin
    loc_count = '0;
    for (int l = 0; l < G; l++) begin
      loc_count = loc_count + CW'(unr[l]);
    end
  end

  assign probe_hit = srch.probe[IW-1:LW] == (IW - LW)'(CELL_ID);
  assign cmd_hit   = cmd.idx[IW-1:LW] == (IW - LW)'(CELL_ID);

  // lower cells take precedence, so an earlier find is passed on unchanged
  always_comb begin
    chain_next.found_hi  = chain_in.found_hi || loc_found_hi;
    chain_next.idx_hi    = chain_in.found_hi ? chain_in.idx_hi
                                             : {(IW - LW)'(CELL_ID), loc_idx_hi};
    chain_next.found_lo  = chain_in.found_lo || loc_found_lo;
    chain_next.idx_lo    = chain_in.found_lo ? chain_in.idx_lo
                                             : {(IW - LW)'(CELL_ID), loc_idx_lo};
    chain_next.probe_occ = chain_in.probe_occ || (probe_hit && occ[srch.probe[LW-1:0]]);
    chain_next.probe_unr = chain_in.probe_unr || (probe_hit && unr[srch.probe[LW-1:0]]);
    chain_next.count     = chain_in.count + loc_count;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occ       <= '0;
      unr       <= '0;
      chain_out <= '0;
    end else begin
      if (cmd.en && cmd_hit) begin
        if (cmd.set_occ) begin
          occ[cmd.idx[LW-1:0]] <= 1'b1;
        end
        if (cmd.clr_occ) begin
          occ[cmd.idx[LW-1:0]] <= 1'b0;
        end
        if (cmd.set_unr) begin
          unr[cmd.idx[LW-1:0]] <= 1'b1;
        end
        if (cmd.clr_unr) begin
          unr[cmd.idx[LW-1:0]] <= 1'b0;
        end
      end
      chain_out <= chain_next;
    end
  end

endmodule

### rtl/receive_ring_slot_manager.sv
`timescale 1ns / 1ps

// Slot manager for one receive endpoint's ring of message slots. The occupied
// and unread bitmaps live in a row of cells, eight slots to a cell; each search
// runs as a wave through the row, one cell per cycle, that carries the first
// free or unread slot (round-robin from write_pos or read_pos), the bits of the
// slot named by message_addr and a running count of unread slots. A word is
// taken through the prepare, address, scan and done states in order; the scan
// state lasts until the wave has reached the end of the row, and one word is
// worked on at a time. A finished result sits in an output register, so the
// next word is taken while it waits. Configuration writes are to be made only
// while the block is idle; the block itself does not enforce this. No clearing
// pass is needed after reset.
module receive_ring_slot_manager #(
  parameter int MAX_SLOTS = rrsm_pkg::DEF_MAX_SLOTS
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // configuration
  input  logic                                  cfg_we,
  input  logic [rrsm_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [rrsm_pkg::ADDR_W-1:0]           cfg_data,
  // request words
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [1:0]                            op,
  input  logic [rrsm_pkg::LEN_W-1:0]            message_length,
  input  logic [rrsm_pkg::ADDR_W-1:0]           message_addr,
  input  logic                                  receive_failed,
  // result words
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [2:0]                            status,
  output logic [4:0]                            slot_index,
  output logic [rrsm_pkg::ADDR_W-1:0]           slot_addr,
  output logic [5:0]                            unread_count
);

  localparam int G     = rrsm_pkg::CELL_SLOTS;
  localparam int CELLS = (MAX_SLOTS + G - 1) / G;
  localparam int XW    = $clog2(CELLS * G);
  localparam int NW    = XW + 1;                 // positions and ring size
  localparam int IW    = rrsm_pkg::IDX_W;
  localparam int CW    = rrsm_pkg::CNT_W;
  localparam int AW    = rrsm_pkg::ADDR_W;
  localparam int LENW  = rrsm_pkg::LEN_W;
  localparam int SCW   = $clog2(CELLS + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_ADDR,
    S_SCAN,
    S_DONE
  } state_t;

  state_t state;

  // configuration registers
  logic [AW-1:0] buffer_base;
  logic [2:0]    slot_count_log2;
  logic [4:0]    slot_size_log2;
  logic [15:0]   endpoint_owner;
  logic [15:0]   running_owner;

  // ring positions
  logic [NW-1:0] write_pos;
  logic [NW-1:0] read_pos;

  // captured word and intermediate results
  rrsm_pkg::op_t     op_q;
  logic [LENW-1:0]   len_q;
  logic [AW-1:0]     addr_q;
  logic              failed_q;
  logic [AW-1:0]     diff_q;
  logic              below_q;
  logic              too_big_q;
  logic              in_range_q;
  logic [SCW-1:0]    scan_cnt;
  rrsm_pkg::search_t srch;

  // derived signals
  logic [8:0]        n_pow;
  logic [NW-1:0]     ring_n;
  logic [NW-1:0]     pos_sel;
  logic [AW:0]       diff_full;
  logic [AW-1:0]     shifted;
  logic              out_free;

  // row of cells
  rrsm_pkg::chain_t  chain [CELLS+1];
  rrsm_pkg::cmd_t    cmd;

  // decisions of the final cycle
  rrsm_pkg::status_t st_d;
  logic [IW-1:0]     idx_d;
  logic [AW-1:0]     addr_d;
  logic [CW-1:0]     cnt_d;
  logic              found;
  logic [IW-1:0]     fidx;
  logic              owner_ok;
  logic              base_ok;
  logic              wpos_upd;
  logic              rpos_upd;
  logic [NW-1:0]     pos_after;

  // ring size: 2^slot_count_log2, capped at the built size
  assign n_pow  = 9'd1 << slot_count_log2;
  assign ring_n = (n_pow > 9'(MAX_SLOTS)) ? NW'(MAX_SLOTS) : NW'(n_pow);

  // a stale position past the ring starts the search at slot zero
  assign pos_sel = (op_q == rrsm_pkg::OP_FETCH) ? read_pos : write_pos;

  assign diff_full = {1'b0, addr_q} - {1'b0, buffer_base};
  assign shifted   = diff_q >> slot_size_log2;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  assign chain[0] = '0;

  for (genvar k = 0; k < CELLS; k++) begin : g_cell
    rrsm_cell #(
      .CELL_ID (k)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .srch      (srch),
      .cmd       (cmd),
      .chain_in  (chain[k]),
      .chain_out (chain[k+1])
    );
  end

  assign owner_ok  = (endpoint_owner == running_owner);
  assign base_ok   = (buffer_base != '0);
  // wrap-around: slots at or above the start come first
  assign found     = chain[CELLS].found_hi || chain[CELLS].found_lo;
  assign fidx      = chain[CELLS].found_hi ? chain[CELLS].idx_hi : chain[CELLS].idx_lo;
  assign pos_after = NW'(CW'(fidx) + CW'(1));

  always_comb begin
    st_d        = rrsm_pkg::STAT_OK;
    idx_d       = '0;
    addr_d      = '0;
    cnt_d       = chain[CELLS].count;
    wpos_upd    = 1'b0;
    rpos_upd    = 1'b0;
    cmd.en      = (state == S_DONE) && out_free;
    cmd.idx     = srch.probe;
    cmd.set_occ = 1'b0;
    cmd.clr_occ = 1'b0;
    cmd.set_unr = 1'b0;
    cmd.clr_unr = 1'b0;
    unique case (op_q)
      rrsm_pkg::OP_ALLOC: begin
        if (!base_ok) begin
          st_d = rrsm_pkg::STAT_INV_EP;
        end else if (too_big_q) begin
          st_d = rrsm_pkg::STAT_TOO_BIG;
        end else if (!found) begin
          st_d = rrsm_pkg::STAT_NO_SPACE;
        end else begin
          idx_d       = fidx;
          addr_d      = buffer_base + (AW'(fidx) << slot_size_log2);
          cmd.idx     = fidx;
          cmd.set_occ = 1'b1;
          wpos_upd    = 1'b1;
        end
      end
      rrsm_pkg::OP_RECV_DONE: begin
        if (!base_ok) begin
          st_d = rrsm_pkg::STAT_INV_EP;
        end else if (!in_range_q) begin
          st_d = rrsm_pkg::STAT_INV_MSG;
        end else if (failed_q) begin
          cmd.clr_occ = 1'b1;
        end else begin
          cmd.set_unr = 1'b1;
          cnt_d       = chain[CELLS].count + CW'(!chain[CELLS].probe_unr);
        end
      end
      rrsm_pkg::OP_FETCH: begin
        if (!owner_ok) begin
          st_d = rrsm_pkg::STAT_INV_EP;
        end else if (!found) begin
          st_d = rrsm_pkg::STAT_EMPTY;
        end else begin
          idx_d       = fidx;
          addr_d      = buffer_base + (AW'(fidx) << slot_size_log2);
          cmd.idx     = fidx;
          cmd.clr_unr = 1'b1;
          cnt_d       = chain[CELLS].count - CW'(1);
          rpos_upd    = 1'b1;
        end
      end
      rrsm_pkg::OP_ACK: begin
        if (!base_ok || !owner_ok) begin
          st_d = rrsm_pkg::STAT_INV_EP;
        end else if (!in_range_q || !chain[CELLS].probe_occ) begin
          st_d = rrsm_pkg::STAT_INV_MSG;
        end else begin
          cmd.clr_occ = 1'b1;
          cmd.clr_unr = 1'b1;
          cnt_d       = chain[CELLS].count - CW'(chain[CELLS].probe_unr);
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      buffer_base     <= '0;
      slot_count_log2 <= '0;
      slot_size_log2  <= '0;
      endpoint_owner  <= '0;
      running_owner   <= '0;
      write_pos       <= '0;
      read_pos        <= '0;
      out_valid       <= 1'b0;
      scan_cnt        <= '0;
      op_q            <= rrsm_pkg::OP_ALLOC;
    end else begin
      // configuration writes
      if (cfg_we) begin
        unique case (cfg_index)
          rrsm_pkg::REG_BUFFER_BASE:     buffer_base     <= cfg_data;
          rrsm_pkg::REG_SLOT_COUNT_LOG2: slot_count_log2 <= cfg_data[2:0];
          rrsm_pkg::REG_SLOT_SIZE_LOG2:  slot_size_log2  <= cfg_data[4:0];
          rrsm_pkg::REG_ENDPOINT_OWNER:  endpoint_owner  <= cfg_data[15:0];
          rrsm_pkg::REG_RUNNING_OWNER:   running_owner   <= cfg_data[15:0];
          default: ;
        endcase
      end

      // a result taken while the next one commits is refilled below
      if (out_valid && out_ready && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            op_q     <= rrsm_pkg::op_t'(op);
            len_q    <= message_length;
            addr_q   <= message_addr;
            failed_q <= receive_failed;
            state    <= S_PREP;
          end
        end
        // offset into the ring, size check, search set-up
        S_PREP: begin
          diff_q           <= diff_full[AW-1:0];
          below_q          <= diff_full[AW];
          too_big_q        <= (slot_size_log2 < 5'd17) &&
                              ({1'b0, len_q} > ((LENW + 1)'(1) << slot_size_log2));
          srch.want_unread <= (op_q == rrsm_pkg::OP_FETCH);
          srch.start       <= (pos_sel >= ring_n) ? '0 : CW'(pos_sel);
          srch.total       <= CW'(ring_n);
          state            <= S_ADDR;
        end
        // slot index of the given address
        S_ADDR: begin
          in_range_q <= !below_q && (shifted < AW'(srch.total));
          srch.probe <= shifted[IW-1:0];
          scan_cnt   <= SCW'(CELLS - 1);
          state      <= S_SCAN;
        end
        // let the wave run to the end of the row
        S_SCAN: begin
          if (scan_cnt == '0) begin
            state <= S_DONE;
          end else begin
            scan_cnt <= scan_cnt - SCW'(1);
          end
        end
        // commit: bitmaps update in the cells on this same edge
        S_DONE: begin
          if (out_free) begin
            out_valid    <= 1'b1;
            status       <= st_d;
            slot_index   <= 5'(idx_d);
            slot_addr    <= addr_d;
            unread_count <= 6'(cnt_d);
            if (wpos_upd) begin
              write_pos <= pos_after;
            end
            if (rpos_upd) begin
              read_pos <= pos_after;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
